FILE: src/ptp_pkg.sv
// shared types and constants for the point to pixel projection core
`timescale 1ns / 1ps

package ptp_pkg;

    localparam int REF_WIDTH  = 640;
    localparam int REF_HEIGHT = 480;
    localparam int QUOT_BITS  = 17;
    localparam int NUM_W      = 64;
    localparam int CRD_W      = 30;

    typedef enum logic [2:0] {
        REG_COS_YAW   = 3'd0,
        REG_SIN_YAW   = 3'd1,
        REG_COS_PITCH = 3'd2,
        REG_SIN_PITCH = 3'd3,
        REG_CAM_X     = 3'd4,
        REG_CAM_Y     = 3'd5,
        REG_CAM_Z     = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic signed [23:0] point_z;
        logic        [7:0]  in_red;
        logic        [7:0]  in_green;
        logic        [7:0]  in_blue;
    } t_in_req;

    typedef struct packed {
        logic               visible;
        logic signed [15:0] pixel_u;
        logic signed [15:0] pixel_v;
        logic signed [23:0] view_depth;
        logic        [7:0]  out_red;
        logic        [7:0]  out_green;
        logic        [7:0]  out_blue;
    } t_out_req;

    typedef struct packed {
        logic signed [15:0] cos_yaw;
        logic signed [15:0] sin_yaw;
        logic signed [15:0] cos_pitch;
        logic signed [15:0] sin_pitch;
        logic signed [23:0] cam_x;
        logic signed [23:0] cam_y;
        logic signed [23:0] cam_z;
    } t_cfg;

    typedef struct packed {
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [CRD_W-1:0] z;
        logic        [23:0]      rgb;
    } t_view;

    // one division lane: partial remainder, divisor, quotient bits, sign and overflow flags
    typedef struct packed {
        logic [NUM_W-1:0]     rem;
        logic [NUM_W-1:0]     den;
        logic [QUOT_BITS-1:0] quot;
        logic                 neg;
        logic                 ovf;
    } t_lane;

    typedef struct packed {
        logic               visible;
        logic signed [23:0] depth;
        logic        [23:0] rgb;
    } t_side;

endpackage

FILE: src/point_to_pixel_projection_core.sv
// top level of the point to pixel projection core
`timescale 1ns / 1ps

// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+---------------------------
// point in  | in        | i_valid / o_stall    | i_req  (ptp_pkg::t_in_req)
// pixel out | out       | o_valid / i_stall    | o_res  (ptp_pkg::t_out_req)
// config    | in        | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// one point per cycle while o_stall is low; the pipe is the transform and prep stages,
// 17 division cells and the output register
// the division chain, one quotient bit per cell, sets the depth of the pipe
// reset is synchronous, active low, and loads the default camera registers
// o_stall is the skid register being full, so it never depends on i_stall

module point_to_pixel_projection_core #(
    parameter int IMAGE_WIDTH  = 640,
    parameter int IMAGE_HEIGHT = 480,
    parameter int FOCAL_REF    = 300
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ptp_pkg::t_in_req  i_req,
    output logic              o_valid,
    input  logic              i_stall,
    output ptp_pkg::t_out_req o_res,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [23:0]       i_cfg_data
);

    localparam int QB     = ptp_pkg::QUOT_BITS;
    localparam int STAGES = 5 + QB;

    // configuration registers; the next value feeds the coefficient stage so
    // a point taken just after a write already sees it
    ptp_pkg::t_cfg r_cfg, n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (!i_rst_n) begin
            n_cfg.cos_yaw   = 16'sd16384;
            n_cfg.sin_yaw   = '0;
            n_cfg.cos_pitch = 16'sd16384;
            n_cfg.sin_pitch = '0;
            n_cfg.cam_x     = '0;
            n_cfg.cam_y     = '0;
            n_cfg.cam_z     = -24'sd25600;
        end else if (i_cfg_we) begin
            unique case (ptp_pkg::t_reg_idx'(i_cfg_idx))
                ptp_pkg::REG_COS_YAW:   n_cfg.cos_yaw   = i_cfg_data[15:0];
                ptp_pkg::REG_SIN_YAW:   n_cfg.sin_yaw   = i_cfg_data[15:0];
                ptp_pkg::REG_COS_PITCH: n_cfg.cos_pitch = i_cfg_data[15:0];
                ptp_pkg::REG_SIN_PITCH: n_cfg.sin_pitch = i_cfg_data[15:0];
                ptp_pkg::REG_CAM_X:     n_cfg.cam_x     = i_cfg_data;
                ptp_pkg::REG_CAM_Y:     n_cfg.cam_y     = i_cfg_data;
                ptp_pkg::REG_CAM_Z:     n_cfg.cam_z     = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

    // the whole pipe moves together unless the skid register holds a request
    logic r_skid_valid;
    logic w_en;
    logic [STAGES-1:0] r_pv;

    assign w_en    = !r_skid_valid;
    assign o_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else if (w_en) begin
            r_pv <= {r_pv[STAGES-2:0], i_valid};
        end
    end

    ptp_pkg::t_view w_view;

    ptp_xform u_xform (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_cfg  (n_cfg),
        .i_req  (i_req),
        .o_view (w_view)
    );

    ptp_pkg::t_lane w_lu [QB+1];
    ptp_pkg::t_lane w_lv [QB+1];
    ptp_pkg::t_side w_sd [QB+1];

    ptp_prep #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT),
        .FOCAL_REF    (FOCAL_REF)
    ) u_prep (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_view   (w_view),
        .o_lane_u (w_lu[0]),
        .o_lane_v (w_lv[0]),
        .o_side   (w_sd[0])
    );

    // division chain, most significant quotient bit first
    for (genvar g = 0; g < QB; g++) begin : g_div
        ptp_div_cell #(
            .STEP (QB - 1 - g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_lane_u (w_lu[g]),
            .i_lane_v (w_lv[g]),
            .i_side   (w_sd[g]),
            .o_lane_u (w_lu[g+1]),
            .o_lane_v (w_lv[g+1]),
            .o_side   (w_sd[g+1])
        );
    end

    // sign restore and saturation of a pixel lane
    function automatic logic signed [15:0] lane_pixel(input ptp_pkg::t_lane l);
        logic signed [15:0] res;
        if (l.neg) begin
            if (l.ovf || l.quot > QB'(32768)) begin
                res = -16'sd32768;
            end else begin
                res = 16'(-l.quot);
            end
        end else begin
            if (l.ovf || l.quot > QB'(32767)) begin
                res = 16'sd32767;
            end else begin
                res = 16'(l.quot);
            end
        end
        return res;
    endfunction

    ptp_pkg::t_out_req w_pipe_res, r_skid;

    always_comb begin
        w_pipe_res.visible    = w_sd[QB].visible;
        w_pipe_res.pixel_u    = w_sd[QB].visible ? lane_pixel(w_lu[QB]) : '0;
        w_pipe_res.pixel_v    = w_sd[QB].visible ? lane_pixel(w_lv[QB]) : '0;
        w_pipe_res.view_depth = w_sd[QB].depth;
        w_pipe_res.out_red    = w_sd[QB].rgb[23:16];
        w_pipe_res.out_green  = w_sd[QB].rgb[15:8];
        w_pipe_res.out_blue   = w_sd[QB].rgb[7:0];
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!o_valid || !i_stall) begin
                o_valid      <= r_skid_valid || r_pv[STAGES-1];
                r_skid_valid <= 1'b0;
            end else if (w_en && r_pv[STAGES-1]) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_valid || !i_stall) begin
            o_res <= r_skid_valid ? r_skid : w_pipe_res;
        end
        if (o_valid && i_stall && w_en) begin
            r_skid <= w_pipe_res;
        end
    end

    // skid only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> o_valid)
        else $error("skid register full without an output request");

    // a hidden point carries no pixel position
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.visible) |-> (o_res.pixel_u == 16'sd0 && o_res.pixel_v == 16'sd0))
        else $error("hidden point with non-zero pixel");

    // visibility agrees with the sign of the depth
    a_vis_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.visible == (o_res.view_depth > 24'sd0)))
        else $error("visible flag disagrees with depth");

endmodule

FILE: src/ptp_xform.sv
// rotation and camera offset, two register stages
`timescale 1ns / 1ps

module ptp_xform (
    input  logic             i_clk,
    input  logic             i_en,
    input  ptp_pkg::t_cfg    i_cfg,
    input  ptp_pkg::t_in_req i_req,
    output ptp_pkg::t_view   o_view
);

    logic signed [31:0] r_cxx, r_cxy, r_cxz, r_cyy, r_cyz, r_czx, r_czy, r_czz;
    logic signed [55:0] r_mxx, r_mxy, r_mxz, r_myy, r_myz, r_mzx, r_mzy, r_mzz;
    logic        [23:0] r_rgb1;
    logic signed [57:0] n_sx, n_sy, n_sz;
    logic signed [29:0] n_rx, n_ry, n_rz;

    // coefficients follow the sine and cosine registers
    always_ff @(posedge i_clk) begin
        r_cxx <= 32'(i_cfg.cos_pitch) <<< 14;
        r_cxy <= 32'(i_cfg.sin_yaw) * 32'(i_cfg.sin_pitch);
        r_cxz <= -(32'(i_cfg.cos_yaw) * 32'(i_cfg.sin_pitch));
        r_cyy <= 32'(i_cfg.cos_yaw) <<< 14;
        r_cyz <= 32'(i_cfg.sin_yaw) <<< 14;
        r_czx <= 32'(i_cfg.sin_pitch) <<< 14;
        r_czy <= -(32'(i_cfg.sin_yaw) * 32'(i_cfg.cos_pitch));
        r_czz <= 32'(i_cfg.cos_yaw) * 32'(i_cfg.cos_pitch);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mxx  <= 56'(r_cxx) * 56'(i_req.point_x);
            r_mxy  <= 56'(r_cxy) * 56'(i_req.point_y);
            r_mxz  <= 56'(r_cxz) * 56'(i_req.point_z);
            r_myy  <= 56'(r_cyy) * 56'(i_req.point_y);
            r_myz  <= 56'(r_cyz) * 56'(i_req.point_z);
            r_mzx  <= 56'(r_czx) * 56'(i_req.point_x);
            r_mzy  <= 56'(r_czy) * 56'(i_req.point_y);
            r_mzz  <= 56'(r_czz) * 56'(i_req.point_z);
            r_rgb1 <= {i_req.in_red, i_req.in_green, i_req.in_blue};
        end
    end

    // round to nearest with ties upward, then drop 28 fraction bits
    always_comb begin
        n_sx = 58'(r_mxx) + 58'(r_mxy) + 58'(r_mxz) + 58'sd134217728;
        n_sy = 58'(r_myy) + 58'(r_myz) + 58'sd134217728;
        n_sz = 58'(r_mzx) + 58'(r_mzy) + 58'(r_mzz) + 58'sd134217728;
        n_rx = 30'(n_sx >>> 28);
        n_ry = 30'(n_sy >>> 28);
        n_rz = 30'(n_sz >>> 28);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_view.x   <= n_rx - 30'(i_cfg.cam_x);
            o_view.y   <= n_ry - 30'(i_cfg.cam_y);
            o_view.z   <= n_rz - 30'(i_cfg.cam_z);
            o_view.rgb <= r_rgb1;
        end
    end

endmodule

FILE: src/ptp_prep.sv
// projection numerators and divisors, sign fold and range check
`timescale 1ns / 1ps

module ptp_prep #(
    parameter int IMAGE_WIDTH  = 640,
    parameter int IMAGE_HEIGHT = 480,
    parameter int FOCAL_REF    = 300
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  ptp_pkg::t_view i_view,
    output ptp_pkg::t_lane o_lane_u,
    output ptp_pkg::t_lane o_lane_v,
    output ptp_pkg::t_side o_side
);

    localparam int NW = ptp_pkg::NUM_W;
    localparam logic signed [27:0] KU = 28'(2 * FOCAL_REF * IMAGE_WIDTH);
    localparam logic signed [27:0] KV = 28'(2 * FOCAL_REF * IMAGE_HEIGHT);
    localparam logic signed [23:0] CU = 24'(ptp_pkg::REF_WIDTH * (IMAGE_WIDTH + 1));
    localparam logic signed [23:0] CV = 24'(ptp_pkg::REF_HEIGHT * (IMAGE_HEIGHT + 1));
    localparam logic signed [11:0] DU = 12'(2 * ptp_pkg::REF_WIDTH);
    localparam logic signed [11:0] DV = 12'(2 * ptp_pkg::REF_HEIGHT);

    logic signed [NW-1:0] r_pxu, r_pzu, r_pyv, r_pzv, r_du, r_dv;
    logic signed [NW-1:0] n_nu, n_nv;
    logic [NW-1:0] r_nu, r_nv, r_du2, r_dv2;
    logic r_negu, r_negv;
    ptp_pkg::t_side r_side3, r_side4;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxu <= NW'(KU) * NW'(i_view.x);
            r_pzu <= NW'(CU) * NW'(i_view.z);
            r_pyv <= NW'(KV) * NW'(i_view.y);
            r_pzv <= NW'(CV) * NW'(i_view.z);
            r_du  <= NW'(DU) * NW'(i_view.z);
            r_dv  <= NW'(DV) * NW'(i_view.z);
            r_side3.visible <= (i_view.z > 30'sd0);
            if (i_view.z > 30'sd8388607) begin
                r_side3.depth <= 24'sd8388607;
            end else if (i_view.z < -30'sd8388608) begin
                r_side3.depth <= -24'sd8388608;
            end else begin
                r_side3.depth <= 24'(i_view.z);
            end
            r_side3.rgb <= i_view.rgb;
        end
    end

    // a negative numerator n becomes d-1-n so that floor turns into truncation
    always_comb begin
        n_nu = r_pxu + r_pzu;
        n_nv = r_pyv + r_pzv;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_negu  <= n_nu[NW-1];
            r_negv  <= n_nv[NW-1];
            r_nu    <= n_nu[NW-1] ? r_du + ~n_nu : n_nu;
            r_nv    <= n_nv[NW-1] ? r_dv + ~n_nv : n_nv;
            r_du2   <= r_du;
            r_dv2   <= r_dv;
            r_side4 <= r_side3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_lane_u.rem  <= r_nu;
            o_lane_u.den  <= r_du2;
            o_lane_u.quot <= '0;
            o_lane_u.neg  <= r_negu;
            o_lane_u.ovf  <= (r_nu >= (r_du2 << ptp_pkg::QUOT_BITS));
            o_lane_v.rem  <= r_nv;
            o_lane_v.den  <= r_dv2;
            o_lane_v.quot <= '0;
            o_lane_v.neg  <= r_negv;
            o_lane_v.ovf  <= (r_nv >= (r_dv2 << ptp_pkg::QUOT_BITS));
            o_side        <= r_side4;
        end
    end

endmodule

FILE: src/ptp_div_cell.sv
// one restoring division step for both pixel lanes
`timescale 1ns / 1ps

module ptp_div_cell #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  ptp_pkg::t_lane i_lane_u,
    input  ptp_pkg::t_lane i_lane_v,
    input  ptp_pkg::t_side i_side,
    output ptp_pkg::t_lane o_lane_u,
    output ptp_pkg::t_lane o_lane_v,
    output ptp_pkg::t_side o_side
);

    localparam int NW = ptp_pkg::NUM_W;

    logic [NW-1:0] n_subu, n_subv;
    ptp_pkg::t_lane n_u, n_v;

    always_comb begin
        n_subu = i_lane_u.rem - (i_lane_u.den << STEP);
        n_subv = i_lane_v.rem - (i_lane_v.den << STEP);
        n_u = i_lane_u;
        n_v = i_lane_v;
        if (!n_subu[NW-1]) begin
            n_u.rem        = n_subu;
            n_u.quot[STEP] = 1'b1;
        end
        if (!n_subv[NW-1]) begin
            n_v.rem        = n_subv;
            n_v.quot[STEP] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_lane_u <= n_u;
            o_lane_v <= n_v;
            o_side   <= i_side;
        end
    end

endmodule
